>>> design/obrb_pkg.sv
package obrb_pkg;

  // Ring geometry and pattern store size.
  localparam int DEPTH       = 256;
  localparam int PATTERN_MAX = 16;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;           // ring address bits
  localparam int CW = $clog2(DEPTH + 1);                         // fill count bits
  localparam int SW = CW + 1;                                    // ring sum bits
  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;  // pattern index bits
  localparam int LW = $clog2(PATTERN_MAX + 1);                   // pattern length bits

  // Fixed field widths of the transactions.
  localparam int KIND_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;
  localparam int AMT_W    = 9;
  localparam int FILL_W   = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 3'd0,
    KIND_READ    = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_PEEK    = 3'd3,
    KIND_QUERY   = 3'd4,
    KIND_PATTERN = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_PAT_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data_byte;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  offset;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_out;
    logic [AMT_W-1:0]    amount;
    logic                overwritten_out;
    logic [FILL_W-1:0]   fill_level;
  } out_t;

  // Advances a ring position; the step never exceeds the ring size.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                             input logic [CW-1:0] step);
    logic [SW-1:0] sum;
    sum = SW'(pos) + SW'(step);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

>>> design/obrb_ram.sv
module obrb_ram #(
  parameter int DEPTH = 256,
  parameter int DW    = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DW-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DW-1:0]                         rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/overwriting_byte_ring_buffer_top.sv
// Overwriting byte ring buffer.
// Input channel in_valid/in_ready/in_data carries one operation per transaction:
// write a byte, read a byte, discard a count, peek at an offset, read and clear
// the sticky overwritten flag, or add a byte to the search pattern. Every input
// transaction yields exactly one result transaction on out_valid/out_ready/out_data.
// Writes, discards, flag queries, kinds six and seven, failed peeks, empty reads
// and pattern bytes without last complete without leaving the idle state: the
// result is registered at the accepting edge. Reads and good peeks pass through
// the READ or PEEK state, since the byte memory has registered read data. A
// closing pattern byte that fits its store and the held bytes starts a naive
// search, which reads the ring one byte per compare through the S_ISSUE and
// S_CMP states. One operation is in flight at a time; a new transaction is taken
// as soon as the block is idle and the output register is empty or being emptied in that same cycle.
// If the receiver stalls, the result waits in the output register and in_ready
// stays low. Reset (rst_n low, synchronous) empties the ring, clears the flag,
// ends any write run and drops any partly collected pattern; memory contents
// are not cleared, since no byte is read before it is written.
module overwriting_byte_ring_buffer_top
  import obrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PEEK,
    ST_S_ISSUE,
    ST_S_CMP
  } state_t;

  state_t state_r, state_nxt;

  // Ring pointers and occupancy.
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] held_r, held_nxt;

  // Sticky flag and write run tracking.
  logic flag_r, flag_nxt;
  logic flag_before_r, flag_before_nxt;
  logic run_act_r, run_act_nxt;
  logic run_nonempty_r, run_nonempty_nxt;

  // Pattern collection.
  logic [BYTE_W-1:0] pat_r [PATTERN_MAX];
  logic [LW-1:0]     plen_r, plen_nxt;
  logic              povl_r, povl_nxt;
  logic              pat_we;

  // Search counters: start offset i and pattern index j.
  logic [LW-1:0] srch_len_r, srch_len_nxt;
  logic [AW-1:0] srch_i_r, srch_i_nxt;
  logic [PW-1:0] srch_j_r, srch_j_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // Byte memory port.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic          acc;
  logic          res_fire;
  out_t          res;
  logic          began;
  logic [CW-1:0] disc_cnt;
  logic [LW-1:0] plen_v;
  logic          povl_v;

  obrb_ram #(
    .DEPTH (DEPTH),
    .DW    (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt        = state_r;
    rp_nxt           = rp_r;
    wp_nxt           = wp_r;
    held_nxt         = held_r;
    flag_nxt         = flag_r;
    flag_before_nxt  = flag_before_r;
    run_act_nxt      = run_act_r;
    run_nonempty_nxt = run_nonempty_r;
    plen_nxt         = plen_r;
    povl_nxt         = povl_r;
    pat_we           = 1'b0;
    srch_len_nxt     = srch_len_r;
    srch_i_nxt       = srch_i_r;
    srch_j_nxt       = srch_j_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    mem_waddr        = wp_r;
    mem_wdata        = in_data.data_byte;
    mem_raddr        = rp_r;
    res              = '0;
    res_fire         = 1'b0;
    began            = 1'b0;
    disc_cnt         = '0;
    plen_v           = plen_r;
    povl_v           = povl_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          flag_before_nxt     = flag_r;
          res.overwritten_out = flag_r;
          if (in_data.kind != KIND_WRITE) begin
            run_act_nxt = 1'b0;
          end
          case (in_data.kind)
            KIND_WRITE: begin
              // The run remembers whether the ring held data when it began.
              began            = run_act_r ? run_nonempty_r : (held_r != '0);
              run_nonempty_nxt = began;
              run_act_nxt      = !in_data.last;
              mem_we           = 1'b1;
              wp_nxt           = ring_add(wp_r, CW'(1));
              if (held_r == CW'(DEPTH)) begin
                rp_nxt = ring_add(rp_r, CW'(1));
                if (began) begin
                  flag_nxt = 1'b1;
                end
              end else begin
                held_nxt = held_r + CW'(1);
              end
              res.amount = AMT_W'(1);
              res_fire   = 1'b1;
            end
            KIND_READ: begin
              flag_nxt = 1'b0;
              if (held_r == '0) begin
                res.status = STAT_EMPTY;
                res_fire   = 1'b1;
              end else begin
                state_nxt = ST_READ;
              end
            end
            KIND_DISCARD: begin
              flag_nxt = 1'b0;
              if (32'(in_data.count) > 32'(held_r)) begin
                disc_cnt = held_r;
              end else begin
                disc_cnt = CW'(in_data.count);
              end
              rp_nxt     = ring_add(rp_r, disc_cnt);
              held_nxt   = held_r - disc_cnt;
              res.amount = AMT_W'(disc_cnt);
              res_fire   = 1'b1;
            end
            KIND_PEEK: begin
              if (32'(in_data.offset) >= 32'(held_r)) begin
                res.status = STAT_RANGE;
                res_fire   = 1'b1;
              end else begin
                mem_raddr = ring_add(rp_r, CW'(in_data.offset));
                state_nxt = ST_PEEK;
              end
            end
            KIND_QUERY: begin
              flag_nxt = 1'b0;
              res_fire = 1'b1;
            end
            KIND_PATTERN: begin
              if (plen_r < LW'(PATTERN_MAX)) begin
                pat_we = 1'b1;
                plen_v = plen_r + LW'(1);
              end else begin
                povl_v = 1'b1;
              end
              if (!in_data.last) begin
                plen_nxt   = plen_v;
                povl_nxt   = povl_v;
                res.amount = AMT_W'(plen_v);
                res_fire   = 1'b1;
              end else begin
                plen_nxt = '0;
                povl_nxt = 1'b0;
                if (povl_v) begin
                  res.status = STAT_PAT_LONG;
                  res_fire   = 1'b1;
                end else if (32'(plen_v) > 32'(held_r)) begin
                  res.status = STAT_NOT_FOUND;
                  res_fire   = 1'b1;
                end else begin
                  srch_len_nxt = plen_v;
                  srch_i_nxt   = '0;
                  srch_j_nxt   = '0;
                  state_nxt    = ST_S_ISSUE;
                end
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        rp_nxt              = ring_add(rp_r, CW'(1));
        held_nxt            = held_r - CW'(1);
        res.data_out        = mem_rdata;
        res.amount          = AMT_W'(1);
        res.overwritten_out = flag_before_r;
        res_fire            = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_PEEK: begin
        res.data_out        = mem_rdata;
        res.overwritten_out = flag_before_r;
        res_fire            = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_S_ISSUE: begin
        mem_raddr = ring_add(rp_r, CW'(srch_i_r) + CW'(srch_j_r));
        state_nxt = ST_S_CMP;
      end
      ST_S_CMP: begin
        res.overwritten_out = flag_before_r;
        if (mem_rdata == pat_r[srch_j_r]) begin
          if (LW'(srch_j_r) + LW'(1) == srch_len_r) begin
            res.amount = AMT_W'(srch_i_r);
            res_fire   = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            srch_j_nxt = srch_j_r + PW'(1);
            state_nxt  = ST_S_ISSUE;
          end
        end else if (CW'(srch_i_r) == held_r - CW'(srch_len_r)) begin
          res.status = STAT_NOT_FOUND;
          res_fire   = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          srch_i_nxt = srch_i_r + AW'(1);
          srch_j_nxt = '0;
          state_nxt  = ST_S_ISSUE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (res_fire) begin
      res.fill_level = FILL_W'(held_nxt);
      out_valid_nxt  = 1'b1;
      out_data_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rp_r           <= '0;
      wp_r           <= '0;
      held_r         <= '0;
      flag_r         <= 1'b0;
      flag_before_r  <= 1'b0;
      run_act_r      <= 1'b0;
      run_nonempty_r <= 1'b0;
      plen_r         <= '0;
      povl_r         <= 1'b0;
      srch_len_r     <= '0;
      srch_i_r       <= '0;
      srch_j_r       <= '0;
      out_valid_r    <= 1'b0;
      out_data_r     <= '0;
    end else begin
      state_r        <= state_nxt;
      rp_r           <= rp_nxt;
      wp_r           <= wp_nxt;
      held_r         <= held_nxt;
      flag_r         <= flag_nxt;
      flag_before_r  <= flag_before_nxt;
      run_act_r      <= run_act_nxt;
      run_nonempty_r <= run_nonempty_nxt;
      plen_r         <= plen_nxt;
      povl_r         <= povl_nxt;
      srch_len_r     <= srch_len_nxt;
      srch_i_r       <= srch_i_nxt;
      srch_j_r       <= srch_j_nxt;
      out_valid_r    <= out_valid_nxt;
      out_data_r     <= out_data_nxt;
    end
  end

  // Pattern bytes carry no reset; only collected bytes are ever compared.
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r[plen_r[PW-1:0]] <= in_data.data_byte;
    end
  end

`ifndef SYNTH
  // The fill count never exceeds the ring size.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("fill count exceeds ring size");

  // An empty or full ring has its read and write pointers together.
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0 || held_r == CW'(DEPTH)) |-> (wp_r == rp_r))
    else $error("ring pointers disagree with fill count");

  // A running search has a nonempty pattern that fits in the held bytes.
  a_srch_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S_ISSUE || state_r == ST_S_CMP) |->
      (srch_len_r != '0 && 32'(srch_len_r) <= 32'(held_r)))
    else $error("search length out of range");

  // A multi-cycle operation only runs while the output register is free.
  a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while an operation is in flight");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Testbench for the overwriting byte ring buffer.
//
// Each input transaction carries one ring operation, and the block answers every
// input transaction with exactly one result transaction. A predictor in this file
// keeps its own copy of the ring: the byte store, the read and write positions,
// the fill count, the sticky overwritten flag, the write-run state and the
// pattern collector. It computes the expected result at the edge where an input
// transaction is accepted and queues it. A checker process pops the oldest
// expected result for every accepted result transaction and compares it field
// by field.
//
// The stimulus has these parts, one task each:
//   - an empty ring: reads, peeks, discards, flag queries, the spare kinds and a
//     one-byte search on an empty ring;
//   - basic operations on a few bytes: write runs broken by other operations,
//     peeks in and out of range, searches whose pattern is interleaved with a
//     read, clamped discards and draining the ring;
//   - overflow: runs that fill the ring from empty, which must not raise the
//     flag, runs into a full ring, which must raise it, a full-length search on a
//     full ring and a pattern longer than its store;
//   - backpressure: the receiver holds off for a long stretch while the sender
//     keeps offering transactions;
//   - random sequences with random content, most of them well formed, and a
//     stretch with no idling on either side.
// Both channels idle at random: most gaps are short and a few are long.
module testbench;
  import obrb_pkg::*;

  // The two kinds the block ignores apart from ending a write run.
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  // Length of the long receiver hold-off, in cycles.
  localparam int LONG_HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Expected results, oldest first.
  out_t results_due[$];
  int   mismatch_count = 0;
  int   items_sent = 0;

  // When set, the sender or the receiver does not idle.
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  // The main process asks for a long hold-off by raising this count; the
  // receiver process serves each request once.
  int   long_hold_requests = 0;

  // Predicted state of the ring.
  logic [7:0]  ring_mem [DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned held = 0;
  bit          overwrite_seen = 1'b0;
  bit          run_open = 1'b0;
  bit          run_had_data = 1'b0;
  logic [7:0]  pat_mem [PATTERN_MAX];
  int unsigned pat_len = 0;
  bit          pat_overflow = 1'b0;

  overwriting_byte_ring_buffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one operation to the predicted ring and returns the result that the
  // block must give for it.
  function automatic out_t apply_ring_op(in_t op);
    out_t        r;
    int unsigned n;
    int unsigned s;
    int unsigned j;
    int unsigned where;
    bit          found;
    bit          hit;
    r = '0;
    r.overwritten_out = overwrite_seen;
    if (op.kind != KIND_WRITE) begin
      run_open = 1'b0;
    end
    case (op.kind)
      KIND_WRITE: begin
        // The first write of a run remembers whether the ring held anything.
        if (!run_open) begin
          run_open = 1'b1;
          run_had_data = (held != 0);
        end
        ring_mem[wr_ptr] = op.data_byte;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (held >= DEPTH) begin
          rd_ptr = (rd_ptr + 1) % DEPTH;
          if (run_had_data) begin
            overwrite_seen = 1'b1;
          end
        end else begin
          held++;
        end
        if (op.last) begin
          run_open = 1'b0;
        end
        r.amount = AMT_W'(1);
      end
      KIND_READ: begin
        overwrite_seen = 1'b0;
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data_out = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          held--;
          r.amount = AMT_W'(1);
        end
      end
      KIND_DISCARD: begin
        overwrite_seen = 1'b0;
        n = (op.count > held) ? held : op.count;
        rd_ptr = (rd_ptr + n) % DEPTH;
        held -= n;
        r.amount = AMT_W'(n);
      end
      KIND_PEEK: begin
        if (op.offset >= held) begin
          r.status = STAT_RANGE;
        end else begin
          r.data_out = ring_mem[(rd_ptr + op.offset) % DEPTH];
        end
      end
      KIND_QUERY: begin
        overwrite_seen = 1'b0;
      end
      KIND_PATTERN: begin
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = op.data_byte;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        if (op.last) begin
          if (pat_overflow) begin
            r.status = STAT_PAT_LONG;
          end else begin
            // Naive search from the oldest byte; the first match wins.
            found = 1'b0;
            where = 0;
            if (pat_len <= held) begin
              for (s = 0; s <= held - pat_len && !found; s++) begin
                hit = 1'b1;
                for (j = 0; j < pat_len; j++) begin
                  if (ring_mem[(rd_ptr + s + j) % DEPTH] != pat_mem[j]) begin
                    hit = 1'b0;
                  end
                end
                if (hit) begin
                  found = 1'b1;
                  where = s;
                end
              end
            end
            if (found) begin
              r.amount = AMT_W'(where);
            end else begin
              r.status = STAT_NOT_FOUND;
            end
          end
          pat_len = 0;
          pat_overflow = 1'b0;
        end else begin
          r.amount = AMT_W'(pat_len);
        end
      end
      default: begin
      end
    endcase
    r.fill_level = FILL_W'(held);
    return r;
  endfunction

  // Idle length in cycles: mostly none, sometimes a few, rarely many.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic in_t make_op(logic [KIND_W-1:0] k, logic [7:0] d, logic l,
                                  logic [COUNT_W-1:0] c, logic [7:0] o);
    in_t op;
    op.kind = k;
    op.data_byte = d;
    op.last = l;
    op.count = c;
    op.offset = o;
    return op;
  endfunction

  // An operation of the given kind with every other field random.
  function automatic in_t rand_op(logic [KIND_W-1:0] k);
    return make_op(k, 8'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  // A peek that mostly lands at or below the fill level, so both outcomes occur.
  function automatic in_t rand_peek();
    in_t op;
    op = rand_op(KIND_PEEK);
    if ($urandom_range(99) < 75) begin
      op.offset = 8'($urandom_range((held > 255) ? 255 : held, 0));
    end
    return op;
  endfunction

  function automatic in_t rand_discard();
    in_t op;
    int  r;
    op = rand_op(KIND_DISCARD);
    r = $urandom_range(99);
    if (r < 70) begin
      op.count = 16'($urandom_range(8, 0));
    end else if (r < 85) begin
      op.count = 16'($urandom_range(300, 0));
    end
    return op;
  endfunction

  // Offers one transaction, waits for it to be accepted and queues the
  // predicted result. Called right after a rising edge.
  task automatic send_op(in_t op);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(apply_ring_op(op));
    if (op.kind <= KIND_PATTERN) begin
      items_sent++;
    end
  endtask

  // A write run of random bytes; the final byte carries last when close is set.
  task automatic send_write_run(int len, bit close);
    in_t op;
    for (int i = 0; i < len; i++) begin
      op = rand_op(KIND_WRITE);
      op.last = close && (i == len - 1);
      send_op(op);
    end
  endtask

  // A pattern of len bytes. With start >= 0 the pattern is copied from the
  // held bytes at that distance from the oldest byte, so that it usually
  // matches; otherwise it is random. Other operations may slip in between.
  task automatic send_pattern(int len, int start);
    logic [7:0] bytes [PATTERN_MAX + 8];
    in_t        op;
    for (int j = 0; j < len; j++) begin
      bytes[j] = (start >= 0) ? ring_mem[(rd_ptr + start + j) % DEPTH] : 8'($urandom);
    end
    for (int j = 0; j < len; j++) begin
      op = rand_op(KIND_PATTERN);
      op.data_byte = bytes[j];
      op.last = (j == len - 1);
      send_op(op);
      if (j < len - 1 && $urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: send_op(rand_peek());
          1: send_op(rand_op(KIND_QUERY));
          2: send_op(rand_op(KIND_SPARE6));
          default: send_write_run(1, 1'b1);
        endcase
      end
    end
  endtask

  task automatic test_empty_ring();
    send_op(make_op(KIND_READ, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'hFF));
    send_op(make_op(KIND_DISCARD, 8'h00, 1'b0, 16'hFFFF, 8'h00));
    send_op(make_op(KIND_QUERY, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_SPARE6, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
    send_op(make_op(KIND_SPARE7, 8'hAA, 1'b0, 16'h5555, 8'h55));
    // A single-byte pattern on an empty ring cannot be found.
    send_op(make_op(KIND_PATTERN, 8'h42, 1'b1, 16'h0000, 8'h00));
  endtask

  task automatic test_basic_ops();
    send_op(make_op(KIND_WRITE, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_WRITE, 8'hFF, 1'b1, 16'h0000, 8'h00));
    // A peek ends the open run; the next write starts a new one.
    send_op(make_op(KIND_WRITE, 8'h5A, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_WRITE, 8'h11, 1'b1, 16'h0000, 8'h00));
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'd3));
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'd4));
    send_op(make_op(KIND_PATTERN, 8'hFF, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_PATTERN, 8'h5A, 1'b1, 16'h0000, 8'h00));
    // Pattern collection carries on across a read.
    send_op(make_op(KIND_PATTERN, 8'h5A, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_READ, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_PATTERN, 8'h11, 1'b1, 16'h0000, 8'h00));
    send_op(make_op(KIND_DISCARD, 8'h00, 1'b0, 16'd1, 8'h00));
    send_op(make_op(KIND_READ, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_READ, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_READ, 8'h00, 1'b0, 16'h0000, 8'h00));
    send_op(make_op(KIND_WRITE, 8'h80, 1'b1, 16'h0000, 8'h00));
    send_op(make_op(KIND_PATTERN, 8'h7F, 1'b1, 16'h0000, 8'h00));
    // The discard count is clamped to the single byte held.
    send_op(make_op(KIND_DISCARD, 8'h00, 1'b0, 16'hFFFF, 8'h00));
  endtask

  task automatic test_overflow_runs();
    send_op(rand_op(KIND_QUERY));
    // Filling from empty past the top drops bytes but must not set the flag.
    send_write_run(DEPTH + 4, 1'b1);
    send_op(rand_op(KIND_QUERY));
    // A run that starts on a full ring sets it.
    send_write_run(3, 1'b1);
    send_op(make_op(KIND_PEEK, 8'h00, 1'b0, 16'h0000, 8'hFF));
    send_op(rand_op(KIND_QUERY));
    send_op(rand_op(KIND_QUERY));
    send_write_run(2, 1'b0);
    send_op(rand_peek());
    send_write_run(2, 1'b1);
    send_op(rand_op(KIND_READ));
    send_write_run(2, 1'b1);
    send_op(make_op(KIND_DISCARD, 8'h00, 1'b0, 16'h0000, 8'h00));
    // The longest search: a full-size pattern taken from the newest bytes.
    send_pattern(PATTERN_MAX, held - PATTERN_MAX);
    send_pattern(PATTERN_MAX + 2, 0);
    send_pattern(PATTERN_MAX, -1);
    send_op(make_op(KIND_DISCARD, 8'h00, 1'b0, 16'hFFFF, 8'h00));
  endtask

  // The receiver holds off while the sender streams without gaps, so the
  // block fills its output register and stalls its input.
  task automatic test_backpressure();
    tx_calm = 1'b1;
    long_hold_requests++;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) begin
        send_op(rand_peek());
      end else begin
        send_write_run(1, 1'b1);
      end
    end
    tx_calm = 1'b0;
  endtask

  task automatic test_random_ops(int target);
    int r;
    int len;
    int start;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 28) begin
        len = $urandom_range(99);
        len = (len < 80) ? $urandom_range(8, 1) :
              (len < 97) ? $urandom_range(40, 9) : $urandom_range(300, 200);
        send_write_run(len, 1'b1);
      end else if (r < 33) begin
        // An unclosed run; the next operation that is not a write ends it.
        send_write_run($urandom_range(6, 1), 1'b0);
      end else if (r < 46) begin
        send_op(rand_op(KIND_READ));
      end else if (r < 55) begin
        send_op(rand_discard());
      end else if (r < 68) begin
        send_op(rand_peek());
      end else if (r < 74) begin
        send_op(rand_op(KIND_QUERY));
      end else if (r < 90) begin
        len = $urandom_range(99);
        len = (len < 80) ? $urandom_range(4, 1) :
              (len < 95) ? $urandom_range(PATTERN_MAX, 5) :
                           $urandom_range(PATTERN_MAX + 4, PATTERN_MAX + 1);
        start = (held > 0 && $urandom_range(99) < 70) ? $urandom_range(held - 1, 0) : -1;
        send_pattern(len, start);
      end else if (r < 96) begin
        repeat ($urandom_range(20, 1)) send_op(rand_op(KIND_READ));
      end else begin
        send_op(rand_op($urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7));
      end
    end
  endtask

  // Random traffic with neither side idling.
  task automatic test_no_idle(int target);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    test_random_ops(target);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Receiver: random stalls, and the long hold-off when one is requested.
  always @(posedge clk) begin
    int stall_left;
    int holds_served;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (holds_served < long_hold_requests) begin
        holds_served++;
        stall_left = LONG_HOLD_CYCLES;
      end else if (!rx_calm && $urandom_range(99) < 25) begin
        stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compares every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_data);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("data_out", want.data_out, out_data.data_out);
        check_field("amount", want.amount, out_data.amount);
        check_field("overwritten_out", want.overwritten_out, out_data.overwritten_out);
        check_field("fill_level", want.fill_level, out_data.fill_level);
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_mem[i] = '0;
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_mem[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_basic_ops();
    test_overflow_runs();
    test_backpressure();
    test_random_ops(750);
    test_no_idle(900);
    test_random_ops(1100);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit: a run that has not finished by this time fails.
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
design/obrb_pkg.sv
design/obrb_ram.sv
design/overwriting_byte_ring_buffer_top.sv
dv/testbench.sv
